@@ rtl/bae_pkg.sv @@
// Shared types and constants for the block average error estimator.
// Used by bae_engine and block_average_error_estimator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bae_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int MAX_BLOCKS   = 1024;

    localparam int SUM_W   = 48;   // sample sum
    localparam int LEN_W   = 16;   // block length / sample count
    localparam int NB_W    = 11;   // block total / block count
    localparam int VSUM_W  = 40;   // sum of block values, Q.16
    localparam int SSUM_W  = 50;   // sum of block squares, Q.16
    localparam int DIV_W   = 50;   // serial divider dividend/quotient
    localparam int RAD_W   = 64;   // serial root radicand
    localparam int ROOT_W  = 32;
    localparam int MUL_W   = 40;   // serial multiplier operand
    localparam int OUT_W   = 32;
    localparam int STEP_W  = 6;

    localparam int DIV_STEPS  = DIV_W;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int MUL_STEPS  = MUL_W;

    // variance clamp, 2^46
    localparam logic [SSUM_W-1:0] VAR_MAX = 50'h4000_0000_0000;

    // APB register map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_BLOCK_LENGTH = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_BLOCK_TOTAL  = 3'd4;

    localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST = 16'd100;
    localparam logic [NB_W-1:0]  BLOCK_TOTAL_RST  = 11'd100;

    typedef enum logic [3:0] {
        E_IDLE,
        E_BDIV,
        E_BSQRT,
        E_BMUL,
        E_RDIV_AVG,
        E_RDIV_M2,
        E_RMUL,
        E_RDIFF,
        E_RDIV_VAR,
        E_RSQRT,
        E_ROUT
    } t_eng_state;

    // closed block handed to the engine
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
        logic [NB_W-1:0]  nb;
    } t_job;

    // finished run from the engine
    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] average;
        logic [OUT_W-1:0] sigma;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/bae_engine.sv @@
// Serial post-processing engine: block mean, root, square and run statistics.
// One bit-serial divider, a two-bit-per-step root unit and a shift-add
// multiplier, sequenced by one FSM. Depends on bae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bae_engine
    import bae_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_out_free,
    output t_res      o_res,
    output logic      o_busy
);

    t_eng_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    logic [DIV_W-1:0]  r_dq, n_dq;
    logic [LEN_W-1:0]  r_drem, n_drem;
    logic [LEN_W-1:0]  r_dvs, n_dvs;
    logic [NB_W-1:0]   r_nb, n_nb;

    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [ROOT_W+1:0] r_srem, n_srem;
    logic [ROOT_W-1:0] r_root, n_root;

    logic [MUL_W-1:0]   r_mula, n_mula;
    logic [2*MUL_W-1:0] r_mulp, n_mulp;

    logic [VSUM_W-1:0] r_vsum, n_vsum;
    logic [SSUM_W-1:0] r_ssum, n_ssum;
    logic [NB_W-1:0]   r_bcnt, n_bcnt;
    logic [VSUM_W-1:0] r_avg, n_avg;
    logic [SSUM_W-1:0] r_mean2, n_mean2;
    logic [ROOT_W-1:0] r_sigma, n_sigma;

    // one step of each serial unit
    logic [LEN_W:0]     s_drsh, s_ddif;
    logic               s_dge;
    logic [DIV_W-1:0]   s_dq;
    logic [LEN_W-1:0]   s_drem;
    logic [ROOT_W+1:0]  s_rsh, s_trial, s_rdif;
    logic               s_rge;
    logic [ROOT_W+1:0]  s_srem;
    logic [ROOT_W-1:0]  s_root;
    logic [RAD_W-1:0]   s_rad;
    logic [MUL_W:0]     s_madd;
    logic [2*MUL_W-1:0] s_mulp;

    logic last_div, last_sqrt, last_mul;
    logic [NB_W-1:0]   bcnt_inc;
    logic [SSUM_W-1:0] avsq;
    logic [OUT_W-1:0]  m_sat;
    logic [46:0]       var_clamp;
    logic              res_valid;

    // restoring divider, one quotient bit per cycle
    assign s_drsh = {r_drem, r_dq[DIV_W-1]};
    assign s_ddif = s_drsh - {1'b0, r_dvs};
    assign s_dge  = (s_drsh >= {1'b0, r_dvs});
    assign s_drem = s_dge ? s_ddif[LEN_W-1:0] : s_drsh[LEN_W-1:0];
    assign s_dq   = {r_dq[DIV_W-2:0], s_dge};

    // digit-by-digit root, two radicand bits per cycle
    assign s_rsh   = {r_srem[ROOT_W-1:0], r_rad[RAD_W-1 -: 2]};
    assign s_trial = {r_root, 2'b01};
    assign s_rdif  = s_rsh - s_trial;
    assign s_rge   = (s_rsh >= s_trial);
    assign s_srem  = s_rge ? s_rdif : s_rsh;
    assign s_root  = {r_root[ROOT_W-2:0], s_rge};
    assign s_rad   = {r_rad[RAD_W-3:0], 2'b00};

    // shift-add multiplier, product in {hi, lo} shifting right
    assign s_madd = {1'b0, r_mulp[2*MUL_W-1:MUL_W]} + (r_mulp[0] ? {1'b0, r_mula} : '0);
    assign s_mulp = {s_madd, r_mulp[MUL_W-1:1]};

    assign last_div  = (r_step == STEP_W'(DIV_STEPS - 1));
    assign last_sqrt = (r_step == STEP_W'(SQRT_STEPS - 1));
    assign last_mul  = (r_step == STEP_W'(MUL_STEPS - 1));

    assign bcnt_inc  = r_bcnt + NB_W'(1);
    assign avsq      = {2'b00, r_mulp[63:16]};
    assign m_sat     = (|s_dq[DIV_W-1:OUT_W]) ? '1 : s_dq[OUT_W-1:0];
    assign var_clamp = (s_dq > VAR_MAX) ? VAR_MAX[46:0] : s_dq[46:0];

    assign o_busy        = (r_state != E_IDLE);
    assign o_res.valid   = res_valid;
    assign o_res.average = (|r_avg[VSUM_W-1:OUT_W]) ? '1 : r_avg[OUT_W-1:0];
    assign o_res.sigma   = r_sigma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_step  <= '0;
            r_vsum  <= '0;
            r_ssum  <= '0;
            r_bcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_vsum  <= n_vsum;
            r_ssum  <= n_ssum;
            r_bcnt  <= n_bcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq    <= n_dq;
        r_drem  <= n_drem;
        r_dvs   <= n_dvs;
        r_nb    <= n_nb;
        r_rad   <= n_rad;
        r_srem  <= n_srem;
        r_root  <= n_root;
        r_mula  <= n_mula;
        r_mulp  <= n_mulp;
        r_avg   <= n_avg;
        r_mean2 <= n_mean2;
        r_sigma <= n_sigma;
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step + STEP_W'(1);
        n_dq      = r_dq;
        n_drem    = r_drem;
        n_dvs     = r_dvs;
        n_nb      = r_nb;
        n_rad     = r_rad;
        n_srem    = r_srem;
        n_root    = r_root;
        n_mula    = r_mula;
        n_mulp    = r_mulp;
        n_vsum    = r_vsum;
        n_ssum    = r_ssum;
        n_bcnt    = r_bcnt;
        n_avg     = r_avg;
        n_mean2   = r_mean2;
        n_sigma   = r_sigma;
        res_valid = 1'b0;

        case (r_state)
            E_IDLE: begin
                n_step = '0;
                if (i_job.start) begin
                    n_dq    = {{(DIV_W-SUM_W){1'b0}}, i_job.sum};
                    n_drem  = '0;
                    n_dvs   = i_job.len;
                    n_nb    = i_job.nb;
                    n_state = E_BDIV;
                end
            end
            E_BDIV: begin
                n_dq   = s_dq;
                n_drem = s_drem;
                if (last_div) begin
                    // block mean Q24.8 -> radicand mean * 2^24
                    n_rad   = {8'b0, m_sat, 24'b0};
                    n_srem  = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = E_BSQRT;
                end
            end
            E_BSQRT: begin
                n_rad  = s_rad;
                n_srem = s_srem;
                n_root = s_root;
                if (last_sqrt) begin
                    n_vsum  = r_vsum + {{(VSUM_W-ROOT_W){1'b0}}, s_root};
                    n_mula  = {{(MUL_W-ROOT_W){1'b0}}, s_root};
                    n_mulp  = {{(2*MUL_W-ROOT_W){1'b0}}, s_root};
                    n_step  = '0;
                    n_state = E_BMUL;
                end
            end
            E_BMUL: begin
                n_mulp = s_mulp;
                if (last_mul) begin
                    n_ssum = r_ssum + {{(SSUM_W-40){1'b0}}, s_mulp[55:16]};
                    n_bcnt = bcnt_inc;
                    n_step = '0;
                    if (bcnt_inc >= r_nb) begin
                        n_dq    = {{(DIV_W-VSUM_W){1'b0}}, r_vsum};
                        n_drem  = '0;
                        n_dvs   = {{(LEN_W-NB_W){1'b0}}, r_nb};
                        n_state = E_RDIV_AVG;
                    end else begin
                        n_state = E_IDLE;
                    end
                end
            end
            E_RDIV_AVG: begin
                n_dq   = s_dq;
                n_drem = s_drem;
                if (last_div) begin
                    n_avg   = s_dq[VSUM_W-1:0];
                    n_dq    = r_ssum;
                    n_drem  = '0;
                    n_step  = '0;
                    n_state = E_RDIV_M2;
                end
            end
            E_RDIV_M2: begin
                n_dq   = s_dq;
                n_drem = s_drem;
                if (last_div) begin
                    n_mean2 = s_dq;
                    n_mula  = r_avg;
                    n_mulp  = {{MUL_W{1'b0}}, r_avg};
                    n_step  = '0;
                    n_state = E_RMUL;
                end
            end
            E_RMUL: begin
                n_mulp = s_mulp;
                if (last_mul) begin
                    n_step  = '0;
                    n_state = E_RDIFF;
                end
            end
            E_RDIFF: begin
                n_step = '0;
                if ((r_nb > NB_W'(1)) && (r_mean2 > avsq)) begin
                    n_dq    = r_mean2 - avsq;
                    n_drem  = '0;
                    n_dvs   = {{(LEN_W-NB_W){1'b0}}, r_nb - NB_W'(1)};
                    n_state = E_RDIV_VAR;
                end else begin
                    n_sigma = '0;
                    n_state = E_ROUT;
                end
            end
            E_RDIV_VAR: begin
                n_dq   = s_dq;
                n_drem = s_drem;
                if (last_div) begin
                    n_rad   = {1'b0, var_clamp, 16'b0};
                    n_srem  = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = E_RSQRT;
                end
            end
            E_RSQRT: begin
                n_rad  = s_rad;
                n_srem = s_srem;
                n_root = s_root;
                if (last_sqrt) begin
                    n_sigma = s_root;
                    n_step  = '0;
                    n_state = E_ROUT;
                end
            end
            E_ROUT: begin
                n_step = '0;
                if (i_out_free) begin
                    res_valid = 1'b1;
                    n_vsum    = '0;
                    n_ssum    = '0;
                    n_bcnt    = '0;
                    n_state   = E_IDLE;
                end
            end
            default: begin
                n_step  = '0;
                n_state = E_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/block_average_error_estimator.sv @@
// Block-averaging standard-error estimator, top level.
// Sample accumulation, APB registers and output register; uses bae_pkg and
// bae_engine.
//
// Samples (unsigned Q24.8) are taken one per cycle while a block fills.
// When a block closes, its sum goes to a serial engine that divides by the
// block length (one quotient bit per step), takes the Q16.16 root (two
// radicand bits per step) and squares it (shift-add), while the next block
// keeps accumulating. A sample that would close a block is stalled until the
// engine has finished the previous one, so within a run a block_length of 123
// or more sustains one sample per cycle. After the last block of a run the
// engine runs two divides, a square, a compare, a third divide and a root (the
// last two are skipped when sigma is forced to zero) and then offers average
// and sigma (Q16.16) on the output register, later if that register is still
// held; the run's accumulators clear as that result is written.
// The source must send exactly block_length x block_total samples per run.
`timescale 1ns / 1ps
`default_nettype none

module block_average_error_estimator
    import bae_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // sample channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    // result channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [OUT_W-1:0]             o_average,
    output logic [OUT_W-1:0]             o_sigma,
    // configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    logic [LEN_W-1:0] r_block_length;
    logic [NB_W-1:0]  r_block_total;
    logic [SUM_W-1:0] r_sample_sum, n_sample_sum;
    logic [LEN_W-1:0] r_sample_count, n_sample_count;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_average, r_sigma;

    logic [LEN_W-1:0] len_eff;
    logic [NB_W-1:0]  nb_eff;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_sat;
    logic [LEN_W-1:0] count_inc;
    logic             closing, accept, cfg_wr, out_free, eng_busy;
    t_job             job;
    t_res             res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr)
            ADDR_BLOCK_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, r_block_length};
            ADDR_BLOCK_TOTAL:  prdata = {{(DATA_W-NB_W){1'b0}}, r_block_total};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LENGTH_RST;
            r_block_total  <= BLOCK_TOTAL_RST;
        end else if (cfg_wr) begin
            if (paddr == ADDR_BLOCK_LENGTH) begin
                r_block_length <= pwdata[LEN_W-1:0];
            end
            if (paddr == ADDR_BLOCK_TOTAL) begin
                r_block_total <= pwdata[NB_W-1:0];
            end
        end
    end

    // zero means one; total clamps at the block limit
    assign len_eff = (r_block_length == '0) ? LEN_W'(1) : r_block_length;
    assign nb_eff  = (r_block_total == '0) ? NB_W'(1) :
                     (r_block_total > NB_W'(MAX_BLOCKS)) ? NB_W'(MAX_BLOCKS) :
                     r_block_total;

    assign sum_add   = {1'b0, r_sample_sum} + {{(SUM_W+1-SAMPLE_WIDTH){1'b0}}, i_sample};
    assign sum_sat   = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign count_inc = r_sample_count + LEN_W'(1);
    assign closing   = (count_inc >= len_eff);

    // only the block-closing transfer waits for the engine
    assign o_stall = eng_busy && closing;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_sample_sum   = r_sample_sum;
        n_sample_count = r_sample_count;
        if (accept) begin
            if (closing) begin
                n_sample_sum   = '0;
                n_sample_count = '0;
            end else begin
                n_sample_sum   = sum_sat;
                n_sample_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_sum   <= '0;
            r_sample_count <= '0;
        end else begin
            r_sample_sum   <= n_sample_sum;
            r_sample_count <= n_sample_count;
        end
    end

    assign job.start = accept && closing;
    assign job.sum   = sum_sat;
    assign job.len   = len_eff;
    assign job.nb    = nb_eff;

    assign out_free = !r_out_valid || !i_stall;

    bae_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (job),
        .i_out_free (out_free),
        .o_res      (res),
        .o_busy     (eng_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_average <= res.average;
            r_sigma   <= res.sigma;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_average;
    assign o_sigma   = r_sigma;

endmodule

`default_nettype wire

@@ tb/block_average_error_estimator_tb.sv @@
// Self-checking testbench for block_average_error_estimator: streams Q24.8
// samples, predicts average and sigma per run, and checks each result transfer.
// Depends on bae_pkg and the block_average_error_estimator RTL only.
`timescale 1ns / 1ps

module block_average_error_estimator_tb;
    import bae_pkg::*;

    localparam int          CYCLE_LIMIT  = 3_000_000;
    localparam int          DRAIN_CYCLES = 500;   // block root plus run close, with margin
    localparam int          HOLD_CYCLES  = 3000;
    localparam logic [63:0] SUM_LIMIT    = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] SPREAD_LIMIT = 64'h0000_4000_0000_0000;
    localparam logic [63:0] WORD_LIMIT   = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [OUT_W-1:0] average;
        logic [OUT_W-1:0] sigma;
    } t_estimate;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [SAMPLE_WIDTH-1:0] i_sample;
    logic                    o_valid;
    logic                    i_stall;
    logic [OUT_W-1:0]        o_average;
    logic [OUT_W-1:0]        o_sigma;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_W-1:0]       paddr;
    logic [DATA_W-1:0]       pwdata;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    // predictor copy of registers and accumulators
    logic [LEN_W-1:0]  set_length;
    logic [NB_W-1:0]   set_blocks;
    logic [SUM_W-1:0]  acc_sum;
    logic [LEN_W-1:0]  acc_count;
    logic [VSUM_W-1:0] root_sum;
    logic [SSUM_W-1:0] square_sum;
    logic [NB_W-1:0]   blocks_done;

    t_estimate   expected_estimates[$];
    int unsigned error_count;
    int unsigned samples_sent;
    int unsigned results_seen;
    int unsigned cycle_count;
    int unsigned stall_hold;
    bit          src_gaps;
    bit          sink_gaps;

    block_average_error_estimator uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_average(o_average),
        .o_sigma  (o_sigma),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("block_average_error_estimator_tb: errors");
        $finish;
    end

    // floor square root, one result bit per pass
    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] draw_sample(input logic [31:0] level);
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(0, 255);
            2: return 32'hFFFF_FFFF;
            3: return 32'h0;
            default: return level ^ $urandom_range(0, 15);   // near-flat blocks
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // Folds one accepted sample into the accumulators; queues an estimate when
    // the sample closes a run.
    task automatic accumulate_sample(input logic [SAMPLE_WIDTH-1:0] s);
        logic [63:0] len_eff, nb_eff, total, mean, val, sq, avg, m2, avsq, spread, sig;
        t_estimate   est;
        len_eff = (set_length == 0) ? 64'd1 : 64'(set_length);
        nb_eff  = (set_blocks == 0) ? 64'd1 : 64'(set_blocks);
        if (nb_eff > MAX_BLOCKS) nb_eff = MAX_BLOCKS;

        total     = 64'(acc_sum) + 64'(s);
        acc_sum   = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
        acc_count = acc_count + 1'b1;
        if (64'(acc_count) < len_eff) return;

        mean = 64'(acc_sum) / len_eff;
        if (mean > WORD_LIMIT) mean = WORD_LIMIT;
        val         = int_root(mean << 24);
        sq          = (val * val) >> 16;
        root_sum    = root_sum + val[VSUM_W-1:0];
        square_sum  = square_sum + sq[SSUM_W-1:0];
        acc_sum     = '0;
        acc_count   = '0;
        blocks_done = blocks_done + 1'b1;
        if (64'(blocks_done) < nb_eff) return;

        avg  = 64'(root_sum) / nb_eff;
        m2   = 64'(square_sum) / nb_eff;
        avsq = (avg * avg) >> 16;
        sig  = '0;
        // one block or a spread lost to truncation leaves sigma at zero
        if (nb_eff > 1 && m2 > avsq) begin
            spread = (m2 - avsq) / (nb_eff - 1);
            if (spread > SPREAD_LIMIT) spread = SPREAD_LIMIT;
            sig = int_root(spread << 16);
        end
        est.average = (avg > WORD_LIMIT) ? 32'hFFFF_FFFF : avg[31:0];
        est.sigma   = (sig > WORD_LIMIT) ? 32'hFFFF_FFFF : sig[31:0];
        expected_estimates.push_back(est);
        root_sum    = '0;
        square_sum  = '0;
        blocks_done = '0;
    endtask

    // Offers one sample and returns at the edge that takes it. Valid stays up
    // on return so back-to-back transfers need no second assignment.
    task automatic push_sample(input logic [SAMPLE_WIDTH-1:0] s);
        if (src_gaps && $urandom_range(99) < 34) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 34) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        accumulate_sample(s);
        samples_sent++;
    endtask

    // Sends until the current run closes, at least one sample.
    task automatic finish_run(input logic [31:0] level);
        push_sample(draw_sample(level));
        while (acc_count != 0 || blocks_done != 0) push_sample(draw_sample(level));
    endtask

    // Source goes quiet until every estimate is in and the engine has wound down.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_estimates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BLOCK_LENGTH) set_length = data[LEN_W-1:0];
        else if (addr == ADDR_BLOCK_TOTAL) set_blocks = data[NB_W-1:0];
    endtask

    task automatic read_reg(input logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] len, input logic [31:0] blocks);
        settle();
        write_reg(ADDR_BLOCK_LENGTH, len);
        write_reg(ADDR_BLOCK_TOTAL, blocks);
    endtask

    task automatic test_register_access();
        logic [DATA_W-1:0] rd;
        read_reg(ADDR_BLOCK_LENGTH, rd);
        compare_field("block_length", 32'(BLOCK_LENGTH_RST), rd);
        read_reg(ADDR_BLOCK_TOTAL, rd);
        compare_field("block_total", 32'(BLOCK_TOTAL_RST), rd);
        write_reg(ADDR_BLOCK_LENGTH, 32'hFFFF_FFFF);
        write_reg(ADDR_BLOCK_TOTAL, 32'hFFFF_FFFF);
        read_reg(ADDR_BLOCK_LENGTH, rd);
        compare_field("block_length", 32'(set_length), rd);
        read_reg(ADDR_BLOCK_TOTAL, rd);
        compare_field("block_total", 32'(set_blocks), rd);
    endtask

    task automatic test_single_block();
        apply_setting(1, 1);
        push_sample(32'h0);
        push_sample(32'hFFFF_FFFF);
        push_sample(32'h1);
        push_sample(32'h100);
        apply_setting(0, 0);   // both act as one
        push_sample(32'hAAAA_AAAA);
        push_sample(32'h5555_5555);
    endtask

    task automatic test_flat_blocks();
        apply_setting(1, 3);
        repeat (3) push_sample(32'h1234_5678);
    endtask

    // Two neighboring means whose truncated squares put mean2 under mean^2.
    task automatic test_negative_spread();
        logic [63:0] m, lo, hi, avg, m2;
        for (m = 17; m < 64'd100000; m++) begin
            lo  = int_root(m << 24);
            hi  = int_root((m + 1) << 24);
            avg = (lo + hi) / 2;
            m2  = (((lo * lo) >> 16) + ((hi * hi) >> 16)) / 2;
            if (((avg * avg) >> 16) > m2) break;
        end
        apply_setting(1, 2);
        push_sample(m[31:0]);
        push_sample(m[31:0] + 32'd1);
    endtask

    task automatic test_midrun_change();
        apply_setting(2, 3);
        repeat (3) push_sample($urandom);
        apply_setting(1, 2);   // sample count already at the new length
        finish_run($urandom);
        apply_setting(1, 4);
        repeat (3) push_sample($urandom);
        apply_setting(1, 2);   // block count already past the new total
        finish_run($urandom);
    endtask

    task automatic test_backpressure();
        apply_setting(1, 1);
        stall_hold <= HOLD_CYCLES;
        repeat (12) push_sample($urandom);
        settle();
    endtask

    // Largest length, then cut to one: the block mean saturates.
    task automatic test_longest_block();
        apply_setting(16'hFFFF, 1);
        repeat (4) push_sample(32'hFFFF_FFFF);
        apply_setting(1, 1);
        finish_run(32'hFFFF_FFFF);
    endtask

    task automatic test_most_blocks();
        apply_setting(1, 11'h7FF);   // clamps to the block limit
        repeat (6) push_sample($urandom);
        apply_setting(1, 2);   // block count already past the new total
        finish_run($urandom);
    endtask

    task automatic test_random_runs();
        int unsigned first_sample, first_result, sent;
        logic [31:0] level;
        first_sample = samples_sent;
        first_result = results_seen;
        while (samples_sent - first_sample < 640 || results_seen - first_result < 40) begin
            sent      = samples_sent - first_sample;
            src_gaps  = !(sent >= 250 && sent < 400);
            sink_gaps = src_gaps;
            // settings stay put through the gap-free stretch
            if (src_gaps) begin
                if ($urandom_range(9) == 0)
                    apply_setting($urandom_range(8, 40), $urandom_range(2, 12));
                else
                    apply_setting($urandom_range(0, 6), $urandom_range(0, 5));
            end
            level = $urandom;
            if ($urandom_range(99) < 15) begin
                // cut short; the next setting lands mid-run
                repeat ($urandom_range(1, 8)) push_sample(draw_sample(level));
            end else begin
                finish_run(level);
            end
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            i_stall    <= 1'b1;
            stall_hold <= stall_hold - 1;
        end else begin
            i_stall <= sink_gaps && ($urandom_range(99) < 34);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_estimate want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_estimates.size() == 0) begin
                $error("unexpected result transfer: average %h, sigma %h", o_average, o_sigma);
                error_count++;
            end else begin
                want = expected_estimates.pop_front();
                compare_field("average", want.average, o_average);
                compare_field("sigma", want.sigma, o_sigma);
                results_seen++;
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_sample    = '0;
        i_stall     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        cycle_count = 0;
        stall_hold  = 0;
        error_count = 0;
        src_gaps    = 1'b1;
        sink_gaps   = 1'b1;
        set_length  = BLOCK_LENGTH_RST;
        set_blocks  = BLOCK_TOTAL_RST;
        acc_sum     = '0;
        acc_count   = '0;
        root_sum    = '0;
        square_sum  = '0;
        blocks_done = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_single_block();
        test_flat_blocks();
        test_negative_spread();
        test_midrun_change();
        test_backpressure();
        test_random_runs();
        test_longest_block();
        test_most_blocks();
        settle();

        $display("summary: %0d samples sent, %0d estimates checked in %0d cycles",
                 samples_sent, results_seen, cycle_count);
        $display("summary: register access, edge settings, mid-run changes, backpressure");
        if (error_count == 0)
            $display("block_average_error_estimator_tb: clean");
        else
            $display("block_average_error_estimator_tb: errors");
        $finish;
    end

endmodule
